// ===== src/ipds_pkg.sv =====
// Shared types, widths and limits of the pixel difference statistics block.
package ipds_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 13;
    localparam int COUNT_W   = 27;
    localparam int SUM_W     = 36;
    localparam int PSUM_W    = PIX_W + 2;     // sum of four channel deltas
    localparam int MARK_W    = PIX_W + 3;     // 40 + 4*max before clamping
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    localparam longint unsigned MAX_SIDE        = 64'd8192;
    localparam longint unsigned CHANNEL_SUM_MAX = 64'd1020;
    localparam longint unsigned COUNT_FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned SUM_FIELD_MAX   = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned COUNT_LIMIT_WIDE = MAX_SIDE * MAX_SIDE;
    localparam longint unsigned SUM_LIMIT_WIDE   = MAX_SIDE * MAX_SIDE * CHANNEL_SUM_MAX;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(
        (COUNT_LIMIT_WIDE < COUNT_FIELD_MAX) ? COUNT_LIMIT_WIDE : COUNT_FIELD_MAX);
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(
        (SUM_LIMIT_WIDE < SUM_FIELD_MAX) ? SUM_LIMIT_WIDE : SUM_FIELD_MAX);

    localparam logic [MARK_W-1:0] MARK_BASE  = MARK_W'(40);
    localparam logic [MARK_W-1:0] MARK_CLAMP = MARK_W'(255);

    localparam logic [COORD_W-1:0] REGION_RIGHT_RESET  = COORD_W'(8191);
    localparam logic [COORD_W-1:0] REGION_BOTTOM_RESET = COORD_W'(8191);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE     = 3'd0,
        REG_REGION_ENABLE = 3'd1,
        REG_REGION_LEFT   = 3'd2,
        REG_REGION_TOP    = 3'd3,
        REG_REGION_RIGHT  = 3'd4,
        REG_REGION_BOTTOM = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [PIX_W-1:0]  max_delta;
        logic [PSUM_W-1:0] delta_sum;
        logic              changed;
        logic [PIX_W-1:0]  mark_alpha;
    } pix_metrics_t;

endpackage

// ===== src/ipds_pixel_math.sv =====
// Per-pixel channel deltas, their maximum and sum, tolerance test and mark alpha.
module ipds_pixel_math
    import ipds_pkg::*;
(
    input  rgba_t            before_px,
    input  rgba_t            after_px,
    input  logic [PIX_W-1:0] tolerance,
    output pix_metrics_t     metrics
);

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [PIX_W-1:0]  d_red;
    logic [PIX_W-1:0]  d_green;
    logic [PIX_W-1:0]  d_blue;
    logic [PIX_W-1:0]  d_alpha;
    logic [PIX_W-1:0]  max_rg;
    logic [PIX_W-1:0]  max_ba;
    logic [PIX_W-1:0]  max_all;
    logic [MARK_W-1:0] mark_wide;

    always_comb
    begin
        d_red   = abs_diff(before_px.red,   after_px.red);
        d_green = abs_diff(before_px.green, after_px.green);
        d_blue  = abs_diff(before_px.blue,  after_px.blue);
        d_alpha = abs_diff(before_px.alpha, after_px.alpha);

        max_rg  = (d_red  > d_green) ? d_red  : d_green;
        max_ba  = (d_blue > d_alpha) ? d_blue : d_alpha;
        max_all = (max_rg > max_ba)  ? max_rg : max_ba;

        // Mark alpha grows four steps per unit of delta, clamped to full scale.
        mark_wide = MARK_BASE + {1'b0, max_all, 2'b00};

        metrics.max_delta = max_all;
        metrics.delta_sum = PSUM_W'(d_red) + PSUM_W'(d_green)
                          + PSUM_W'(d_blue) + PSUM_W'(d_alpha);
        metrics.changed   = (max_all > tolerance);
        if (!metrics.changed)
        begin
            metrics.mark_alpha = '0;
        end
        else if (mark_wide > MARK_CLAMP)
        begin
            metrics.mark_alpha = MARK_CLAMP[PIX_W-1:0];
        end
        else
        begin
            metrics.mark_alpha = mark_wide[PIX_W-1:0];
        end
    end

endmodule

// ===== src/image_pixel_diff_statistics_core.sv =====
// Top level of the pixel difference statistics block: handshakes, registers, accumulators.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel pair per word: column,
//   row, RGBA before, RGBA after and a last_pixel flag that closes the image.
//   Output channel (out_valid / out_stall) returns one word per input word with
//   the tolerance flag, mark alpha and the running image statistics, which
//   already include that pixel. After the word flagged last_pixel is produced,
//   all statistics restart from zero for the next image.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes the
//   tolerance and allowed rectangle by index; write only while the block is idle.
// Timing:
//   An accepted input word passes through one input register, then the delta
//   math and accumulator update feed the result register. One word per cycle
//   is sustained while the receiver does not stall; the statistics feedback
//   through the result register is the recurrence that sets this rate.
// Reset and stall:
//   rst_n clears both pipeline valid flags, resets the configuration registers and
//   sets pending-clear so statistics restart from zero. On a stall the result word
//   holds and the input register keeps its word; in_stall needs both stages full.
module image_pixel_diff_statistics_core
    import ipds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_W-1:0]     pixel_x,
    input  logic [COORD_W-1:0]     pixel_y,
    input  logic [PIX_W-1:0]       before_red,
    input  logic [PIX_W-1:0]       before_green,
    input  logic [PIX_W-1:0]       before_blue,
    input  logic [PIX_W-1:0]       before_alpha,
    input  logic [PIX_W-1:0]       after_red,
    input  logic [PIX_W-1:0]       after_green,
    input  logic [PIX_W-1:0]       after_blue,
    input  logic [PIX_W-1:0]       after_alpha,
    input  logic                   last_pixel,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   pixel_changed,
    output logic [PIX_W-1:0]       mark_alpha,
    output logic [PIX_W-1:0]       peak_delta,
    output logic [COUNT_W-1:0]     any_change_count,
    output logic [COUNT_W-1:0]     over_tolerance_count,
    output logic [COUNT_W-1:0]     outside_region_count,
    output logic [SUM_W-1:0]       delta_total,
    output logic                   box_valid,
    output logic [COORD_W-1:0]     box_left,
    output logic [COORD_W-1:0]     box_top,
    output logic [COORD_W-1:0]     box_right,
    output logic [COORD_W-1:0]     box_bottom
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]   tolerance_reg;
    logic               region_en_reg;
    logic [COORD_W-1:0] region_left_reg;
    logic [COORD_W-1:0] region_top_reg;
    logic [COORD_W-1:0] region_right_reg;
    logic [COORD_W-1:0] region_bottom_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= '0;
            region_en_reg     <= 1'b0;
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= REGION_RIGHT_RESET;
            region_bottom_reg <= REGION_BOTTOM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Drop writes to indexes beyond the register list.
            case (cfg_reg_t'(cfg_index))
                REG_TOLERANCE:     tolerance_reg     <= cfg_data[PIX_W-1:0];
                REG_REGION_ENABLE: region_en_reg     <= cfg_data[0];
                REG_REGION_LEFT:   region_left_reg   <= cfg_data[COORD_W-1:0];
                REG_REGION_TOP:    region_top_reg    <= cfg_data[COORD_W-1:0];
                REG_REGION_RIGHT:  region_right_reg  <= cfg_data[COORD_W-1:0];
                REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_load;     // result register may take a new word
    logic advance;      // input register moves into result register
    logic in_accept;

    assign out_load  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    rgba_t              before_reg;
    rgba_t              after_reg;
    logic               last_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg      <= pixel_x;
            y_reg      <= pixel_y;
            before_reg <= '{red: before_red, green: before_green,
                            blue: before_blue, alpha: before_alpha};
            after_reg  <= '{red: after_red, green: after_green,
                            blue: after_blue, alpha: after_alpha};
            last_reg   <= last_pixel;
        end
    end

    pix_metrics_t metrics;

    ipds_pixel_math u_pixel_math (
        .before_px (before_reg),
        .after_px  (after_reg),
        .tolerance (tolerance_reg),
        .metrics   (metrics)
    );

    // ---------------------------------------------------------------
    // Statistics: the result register doubles as the accumulator. A
    // pending-clear flag makes the next pixel start from zero after the
    // last pixel of an image, without touching the word still on display.
    // ---------------------------------------------------------------
    logic               clear_pend_reg;

    logic               changed_reg;
    logic [PIX_W-1:0]   mark_reg;
    logic [PIX_W-1:0]   peak_reg;
    logic [COUNT_W-1:0] any_cnt_reg;
    logic [COUNT_W-1:0] over_cnt_reg;
    logic [COUNT_W-1:0] outside_cnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               box_valid_reg;
    logic [COORD_W-1:0] box_left_reg;
    logic [COORD_W-1:0] box_top_reg;
    logic [COORD_W-1:0] box_right_reg;
    logic [COORD_W-1:0] box_bottom_reg;

    logic [PIX_W-1:0]   peak_next;
    logic [COUNT_W-1:0] any_cnt_next;
    logic [COUNT_W-1:0] over_cnt_next;
    logic [COUNT_W-1:0] outside_cnt_next;
    logic [SUM_W-1:0]   sum_next;
    logic               box_valid_next;
    logic [COORD_W-1:0] box_left_next;
    logic [COORD_W-1:0] box_top_next;
    logic [COORD_W-1:0] box_right_next;
    logic [COORD_W-1:0] box_bottom_next;

    logic [PIX_W-1:0]   peak_base;
    logic [COUNT_W-1:0] any_base;
    logic [COUNT_W-1:0] over_base;
    logic [COUNT_W-1:0] outside_base;
    logic [SUM_W-1:0]   sum_base;
    logic               box_valid_base;
    logic [SUM_W:0]     sum_wide;
    logic               in_region;

    always_comb
    begin
        peak_base      = clear_pend_reg ? '0   : peak_reg;
        any_base       = clear_pend_reg ? '0   : any_cnt_reg;
        over_base      = clear_pend_reg ? '0   : over_cnt_reg;
        outside_base   = clear_pend_reg ? '0   : outside_cnt_reg;
        sum_base       = clear_pend_reg ? '0   : sum_reg;
        box_valid_base = clear_pend_reg ? 1'b0 : box_valid_reg;

        peak_next = (metrics.max_delta > peak_base) ? metrics.max_delta : peak_base;

        // Saturate the delta total at its image-size bound.
        sum_wide = {1'b0, sum_base} + (SUM_W + 1)'(metrics.delta_sum);
        sum_next = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_wide[SUM_W-1:0];

        any_cnt_next = any_base;
        if (metrics.max_delta != '0)
        begin
            any_cnt_next = (any_base < COUNT_LIMIT) ? any_base + 1'b1 : COUNT_LIMIT;
        end

        in_region = (x_reg >= region_left_reg) && (x_reg <= region_right_reg) &&
                    (y_reg >= region_top_reg)  && (y_reg <= region_bottom_reg);

        over_cnt_next    = over_base;
        outside_cnt_next = outside_base;
        if (metrics.changed)
        begin
            over_cnt_next = (over_base < COUNT_LIMIT) ? over_base + 1'b1 : COUNT_LIMIT;
            if (region_en_reg && !in_region)
            begin
                outside_cnt_next = (outside_base < COUNT_LIMIT) ?
                                   outside_base + 1'b1 : COUNT_LIMIT;
            end
        end

        // Bounding box: seed on the first changed pixel, grow afterward;
        // an empty box reads as all zero.
        box_valid_next = box_valid_base || metrics.changed;
        if (!box_valid_base)
        begin
            box_left_next   = metrics.changed ? x_reg : '0;
            box_top_next    = metrics.changed ? y_reg : '0;
            box_right_next  = metrics.changed ? x_reg : '0;
            box_bottom_next = metrics.changed ? y_reg : '0;
        end
        else
        begin
            box_left_next   = box_left_reg;
            box_top_next    = box_top_reg;
            box_right_next  = box_right_reg;
            box_bottom_next = box_bottom_reg;
            if (metrics.changed)
            begin
                if (x_reg < box_left_reg)   box_left_next   = x_reg;
                if (y_reg < box_top_reg)    box_top_next    = y_reg;
                if (x_reg > box_right_reg)  box_right_next  = x_reg;
                if (y_reg > box_bottom_reg) box_bottom_next = y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pend_reg <= 1'b1;
        end
        else if (advance)
        begin
            clear_pend_reg <= last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            changed_reg     <= metrics.changed;
            mark_reg        <= metrics.mark_alpha;
            peak_reg        <= peak_next;
            any_cnt_reg     <= any_cnt_next;
            over_cnt_reg    <= over_cnt_next;
            outside_cnt_reg <= outside_cnt_next;
            sum_reg         <= sum_next;
            box_valid_reg   <= box_valid_next;
            box_left_reg    <= box_left_next;
            box_top_reg     <= box_top_next;
            box_right_reg   <= box_right_next;
            box_bottom_reg  <= box_bottom_next;
        end
    end

    assign pixel_changed        = changed_reg;
    assign mark_alpha           = mark_reg;
    assign peak_delta           = peak_reg;
    assign any_change_count     = any_cnt_reg;
    assign over_tolerance_count = over_cnt_reg;
    assign outside_region_count = outside_cnt_reg;
    assign delta_total          = sum_reg;
    assign box_valid            = box_valid_reg;
    assign box_left             = box_left_reg;
    assign box_top              = box_top_reg;
    assign box_right            = box_right_reg;
    assign box_bottom           = box_bottom_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_changed_has_box: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_changed) |-> box_valid)
        else $error("changed pixel reported without a valid box");

    a_mark_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_changed ? (mark_alpha >= PIX_W'(40)) : (mark_alpha == '0)))
        else $error("mark alpha disagrees with change flag");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && box_valid) |-> ((box_left <= box_right) && (box_top <= box_bottom)))
        else $error("bounding box corners out of order");

    a_counts_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (over_tolerance_count <= any_change_count))
        else $error("over-tolerance count exceeds any-change count");

endmodule
